// ----- hdl/derq_pkg.sv -----
// Shared types and constants for the double-ended ring queue.
package derq_pkg;

    localparam int ACTION_W   = 2;
    localparam int ITEM_W     = 32;
    localparam int COUNT_W    = 5;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SEND_BACK  = 2'd0,
        ACT_SEND_FRONT = 2'd1,
        ACT_OVERWRITE  = 2'd2,
        ACT_RECEIVE    = 2'd3
    } action_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CAPACITY   = 2'd0,
        CFG_INIT_COUNT = 2'd1
    } cfg_reg_t;

    localparam logic [COUNT_W-1:0] CAPACITY_RST   = 5'd16;
    localparam logic [COUNT_W-1:0] INIT_COUNT_RST = 5'd0;

endpackage

// ----- hdl/double_ended_ring_queue.sv -----
// Double-ended ring queue: message queue / counting semaphore top level.
//
// Requests enter on the s_ stream (action + data word), one result per request
// leaves on the m_ stream (ok flag, word received, item count afterwards).
// When a request is taken, the indices, the count and one storage
// write are updated at the accepting edge, and a receive reads the ring at the
// same edge into a registered read port. The result goes through one holding
// stage and then the output register before it shows on m_. One request per
// cycle is sustained while m_tready is high; with the output stalled, one more
// request is still taken into the holding stage before s_tready drops.
// Reset (rst_n low) empties the pipeline, sets capacity 16, initial count 0,
// write index 0 and read index capacity minus one. A write to the capacity or
// initial-count register on the cfg_ port reinitializes indices and count the
// same way; ring contents are kept and are not cleared at reset. The count preset
// by initial_count must not be received from slots that were never written.
module double_ended_ring_queue
    import derq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // s_tdata: action[1:0], item_in[33:2], zero fill [39:34]
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    // m_tdata: ok[0], item_out[32:1], fill_count[37:33], zero fill [39:38]
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    input  logic                    cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int SLOTS = (DEPTH < 31) ? DEPTH : 31;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [DATA_WIDTH-1:0] ring_mem [SLOTS];

    logic [COUNT_W-1:0]    capacity_reg, capacity_next;
    logic [COUNT_W-1:0]    init_count_reg, init_count_next;
    logic [IDX_W-1:0]      write_idx_reg, write_idx_next;
    logic [IDX_W-1:0]      read_idx_reg, read_idx_next;
    logic [COUNT_W-1:0]    count_reg, count_next;

    logic                  s1_valid_reg;
    logic                  s1_ok_reg, s1_ok_next;
    logic                  s1_rx_reg, s1_rx_next;
    logic [COUNT_W-1:0]    s1_count_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic                  out_valid_reg;
    logic                  out_ok_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;

    logic                  accept, s1_move, cfg_hit;
    logic [COUNT_W-1:0]    cap_eff, cap_eff_new;
    logic                  full, empty;
    logic [IDX_W-1:0]      rd_up, rd_down, wr_up;
    logic                  mem_we, mem_re;
    logic [IDX_W-1:0]      mem_waddr;
    logic [DATA_WIDTH-1:0] item_in;
    action_t               action;

    function automatic logic [COUNT_W-1:0] eff_cap(input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] r;
        r = c;
        if (c == '0)
            r = COUNT_W'(1);
        else if (int'(c) > DEPTH)
            r = COUNT_W'(DEPTH);
        return r;
    endfunction

    assign action   = action_t'(s_tdata[ACTION_W-1:0]);
    assign item_in  = DATA_WIDTH'(s_tdata[ACTION_W+ITEM_W-1:ACTION_W]);

    assign s1_move  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;
    assign accept   = s_tvalid && s_tready;

    assign cap_eff  = eff_cap(capacity_reg);
    assign full     = count_reg >= cap_eff;
    assign empty    = count_reg == '0;
    assign rd_up    = ((COUNT_W'(read_idx_reg) + COUNT_W'(1)) >= cap_eff) ? '0
                                                                         : read_idx_reg + 1'b1;
    assign wr_up    = ((COUNT_W'(write_idx_reg) + COUNT_W'(1)) >= cap_eff) ? '0
                                                                          : write_idx_reg + 1'b1;
    assign rd_down  = (read_idx_reg == '0) ? IDX_W'(cap_eff - COUNT_W'(1))
                                           : read_idx_reg - 1'b1;

    // configuration
    always_comb
    begin
        capacity_next   = capacity_reg;
        init_count_next = init_count_reg;
        cfg_hit         = 1'b0;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_CAPACITY:
                begin
                    capacity_next = cfg_wdata;
                    cfg_hit       = 1'b1;
                end
                CFG_INIT_COUNT:
                begin
                    init_count_next = cfg_wdata;
                    cfg_hit         = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    assign cap_eff_new = eff_cap(capacity_next);

    // request decode
    always_comb
    begin
        write_idx_next = write_idx_reg;
        read_idx_next  = read_idx_reg;
        count_next     = count_reg;
        s1_ok_next     = 1'b0;
        s1_rx_next     = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = write_idx_reg;
        unique case (action)
            ACT_SEND_BACK:
            begin
                if (!full)
                begin
                    mem_we         = 1'b1;
                    write_idx_next = wr_up;
                    count_next     = count_reg + 1'b1;
                    s1_ok_next     = 1'b1;
                end
            end
            ACT_SEND_FRONT:
            begin
                if (!full)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = read_idx_reg;
                    read_idx_next = rd_down;
                    count_next    = count_reg + 1'b1;
                    s1_ok_next    = 1'b1;
                end
            end
            ACT_OVERWRITE:
            begin
                mem_we     = 1'b1;
                s1_ok_next = 1'b1;
                if (full)
                begin
                    mem_waddr = rd_up;  // replace front item in place
                end
                else
                begin
                    mem_waddr     = read_idx_reg;
                    read_idx_next = rd_down;
                    count_next    = count_reg + 1'b1;
                end
            end
            ACT_RECEIVE:
            begin
                if (!empty)
                begin
                    mem_re        = 1'b1;
                    read_idx_next = rd_up;
                    count_next    = count_reg - 1'b1;
                    s1_ok_next    = 1'b1;
                    s1_rx_next    = 1'b1;
                end
            end
            default:
            begin
                s1_ok_next = 1'b0;
            end
        endcase
    end

    // ring storage
    always_ff @(posedge clk)
    begin
        if (accept && mem_we)
            ring_mem[mem_waddr] <= item_in;
    end

    always_ff @(posedge clk)
    begin
        if (accept && mem_re)
            rd_data_reg <= ring_mem[rd_up];
    end

    // queue state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= CAPACITY_RST;
            init_count_reg <= INIT_COUNT_RST;
            write_idx_reg  <= '0;
            read_idx_reg   <= IDX_W'(eff_cap(CAPACITY_RST) - COUNT_W'(1));
            count_reg      <= (INIT_COUNT_RST > eff_cap(CAPACITY_RST)) ?
                              eff_cap(CAPACITY_RST) : INIT_COUNT_RST;
        end
        else if (cfg_hit)
        begin
            capacity_reg   <= capacity_next;
            init_count_reg <= init_count_next;
            write_idx_reg  <= '0;
            read_idx_reg   <= IDX_W'(cap_eff_new - COUNT_W'(1));
            count_reg      <= (init_count_next > cap_eff_new) ? cap_eff_new : init_count_next;
        end
        else if (accept)
        begin
            write_idx_reg <= write_idx_next;
            read_idx_reg  <= read_idx_next;
            count_reg     <= count_next;
        end
    end

    // result pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ok_reg    <= s1_ok_next;
            s1_rx_reg    <= s1_rx_next;
            s1_count_reg <= count_next;
        end
        if (s1_move)
        begin
            out_ok_reg    <= s1_ok_reg;
            out_count_reg <= s1_count_reg;
            out_data_reg  <= s1_rx_reg ? rd_data_reg : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_count_reg, ITEM_W'(out_data_reg), out_ok_reg};

endmodule

// ----- hdl/derq_checker.sv -----
// Port-level checks for the double-ended ring queue, bound to the top level.
module derq_checker
    import derq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int MAX_FILL = (DEPTH < 31) ? DEPTH : 31;

    logic unused_in;
    assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_data_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'd0)
        else $error("data word on a refused request");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> int'(m_tdata[37:33]) <= MAX_FILL)
        else $error("item count above capacity");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:38] == 2'b00)
        else $error("nonzero fill bits in result");

endmodule

bind double_ended_ring_queue derq_checker #(.DEPTH(DEPTH)) u_derq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/tb_double_ended_ring_queue.sv -----
`timescale 1ns / 1ps
// Testbench for the double-ended ring queue: directed and random requests checked against a ring predictor.
module tb_double_ended_ring_queue
    import derq_pkg::*;
();

    localparam int RING_SLOTS = 16;
    localparam int STALL_LIMIT = 2000;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic               ok;
        logic [ITEM_W-1:0]  word;
        logic [COUNT_W-1:0] count;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = CFG_CAPACITY;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    double_ended_ring_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [ITEM_W-1:0] ring_mem [RING_SLOTS];
    bit ring_written [RING_SLOTS];
    int unsigned wr_idx;
    int unsigned rd_idx;
    int unsigned held;
    int unsigned cap_reg = CAPACITY_RST;
    int unsigned init_reg = INIT_COUNT_RST;

    logic [IN_TDATA_W-1:0] request_q [$];
    reply_t expected_replies [$];
    int send_gap_pct = 31;
    int recv_stall_pct = 58;
    int mismatches = 0;
    int quiet_cycles = 0;
    logic req_taken;
    reply_t got_reply;
    reply_t want_reply;

    function automatic int unsigned ring_size();
        if (cap_reg == 0)
            return 1;
        if (cap_reg > RING_SLOTS)
            return RING_SLOTS;
        return cap_reg;
    endfunction

    function automatic int unsigned slot_after(int unsigned i, int unsigned cap);
        return (i + 1 >= cap) ? 0 : i + 1;
    endfunction

    function automatic int unsigned slot_before(int unsigned i, int unsigned cap);
        return (i == 0 || i >= cap) ? cap - 1 : i - 1;
    endfunction

    function automatic void reload_indices();
        int unsigned cap;
        cap = ring_size();
        wr_idx = 0;
        rd_idx = cap - 1;
        held = (init_reg > cap) ? cap : init_reg;
    endfunction

    function automatic void store_word(int unsigned slot, logic [ITEM_W-1:0] data);
        ring_mem[slot] = data;
        ring_written[slot] = 1'b1;
    endfunction

    function automatic reply_t predict_request(action_t act, logic [ITEM_W-1:0] data);
        int unsigned cap;
        bit full;
        reply_t r;
        cap = ring_size();
        full = (held >= cap);
        r = '0;
        if (wr_idx >= cap)
            wr_idx = 0;
        if (rd_idx >= cap)
            rd_idx = cap - 1;
        case (act) inside
            ACT_SEND_BACK:
                if (!full)
                begin
                    store_word(wr_idx, data);
                    wr_idx = slot_after(wr_idx, cap);
                    held++;
                    r.ok = 1'b1;
                end
            ACT_SEND_FRONT, ACT_OVERWRITE:
                if (!full)
                begin
                    store_word(rd_idx, data);
                    rd_idx = slot_before(rd_idx, cap);
                    held++;
                    r.ok = 1'b1;
                end
                else if (act == ACT_OVERWRITE)
                begin
                    store_word(slot_after(rd_idx, cap), data);
                    r.ok = 1'b1;
                end
            ACT_RECEIVE:
                if (held > 0)
                begin
                    rd_idx = slot_after(rd_idx, cap);
                    r.word = ring_mem[rd_idx];
                    held--;
                    r.ok = 1'b1;
                end
            default: ;
        endcase
        r.count = COUNT_W'(held);
        return r;
    endfunction

    // a receive that would hit a never-written slot becomes a send to back
    task automatic issue(action_t act, logic [ITEM_W-1:0] data);
        if (act == ACT_RECEIVE && held > 0 &&
            !ring_written[slot_after(rd_idx < ring_size() ? rd_idx : ring_size() - 1,
                                     ring_size())])
            act = ACT_SEND_BACK;
        expected_replies.push_back(predict_request(act, data));
        request_q.push_back({{(IN_TDATA_W-ITEM_W-ACTION_W){1'b0}}, data, act});
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (addr)
            CFG_CAPACITY:
            begin
                cap_reg = value;
                reload_indices();
            end
            CFG_INIT_COUNT:
            begin
                init_reg = value;
                reload_indices();
            end
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic settle();
        while (request_q.size() != 0 || expected_replies.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic random_run(int n);
        int drain_pct;
        action_t act;
        logic [ITEM_W-1:0] data;
        drain_pct = 50;
        for (int i = 0; i < n; i++)
        begin
            if (i % 24 == 0)
                case ($urandom_range(2))
                    0: drain_pct = 15;
                    1: drain_pct = 50;
                    default: drain_pct = 85;
                endcase
            if ($urandom_range(99) < drain_pct)
                act = ACT_RECEIVE;
            else
                act = action_t'($urandom_range(2));
            case ($urandom_range(15))
                0: data = '0;
                1: data = '1;
                default: data = $urandom();
            endcase
            issue(act, data);
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_taken <= 1'b0;
        else
            req_taken <= s_tvalid && s_tready;
    end

    always @(negedge clk)
    begin
        if (req_taken)
            void'(request_q.pop_front());
        if (!(s_tvalid && !req_taken))
        begin
            if (rst_n && request_q.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= request_q[0];
            end
            else
                s_tvalid <= 1'b0;
        end
        m_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // reply monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_reply.ok = m_tdata[0];
            got_reply.word = m_tdata[32:1];
            got_reply.count = m_tdata[37:33];
            if (expected_replies.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected reply: ok=%0b word=%h count=%0d",
                             got_reply.ok, got_reply.word, got_reply.count);
                mismatches++;
            end
            else
            begin
                want_reply = expected_replies.pop_front();
                if (got_reply.ok !== want_reply.ok || got_reply.word !== want_reply.word ||
                    got_reply.count !== want_reply.count)
                begin
                    if (mismatches < 10)
                        $display("mismatch: exp %0b %h %0d got %0b %h %0d",
                                 want_reply.ok, want_reply.word, want_reply.count,
                                 got_reply.ok, got_reply.word, got_reply.count);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        reload_indices();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(ACT_RECEIVE, 32'h0000_0000);
        issue(ACT_SEND_BACK, 32'h0000_0000);
        issue(ACT_SEND_BACK, 32'hFFFF_FFFF);
        issue(ACT_SEND_FRONT, 32'hA5A5_A5A5);
        issue(ACT_OVERWRITE, 32'h5A5A_5A5A);
        repeat (4) issue(ACT_RECEIVE, 32'hFFFF_FFFF);
        issue(ACT_RECEIVE, 32'h0000_0000);
        settle();
        write_reg(CFG_CAPACITY, 5'd2);
        issue(ACT_SEND_BACK, 32'h1234_5678);
        issue(ACT_SEND_BACK, 32'h8765_4321);
        issue(ACT_SEND_BACK, 32'hDEAD_BEEF);
        issue(ACT_SEND_FRONT, 32'hCAFE_F00D);
        issue(ACT_OVERWRITE, 32'h0F0F_0F0F);
        repeat (3) issue(ACT_RECEIVE, 32'h0000_0000);

        for (int ph = 0; ph < 12; ph++)
        begin
            int caps [12];
            int inits [12];
            caps = '{16, 1, 0, 31, 5, 17, 2, 16, 8, 1, 3, 16};
            inits = '{0, 0, 1, 31, 3, 16, 0, 12, 8, 1, 2, 16};
            settle();
            if (ph == 4)
            begin
                send_gap_pct = 58;
                recv_stall_pct = 31;
            end
            else if (ph == 8)
            begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            if (ph % 2 == 1)
            begin
                write_reg(CFG_INIT_COUNT, CFG_DATA_W'(inits[ph]));
                write_reg(CFG_CAPACITY, CFG_DATA_W'(caps[ph]));
            end
            else
            begin
                write_reg(CFG_CAPACITY, CFG_DATA_W'(caps[ph]));
                write_reg(CFG_INIT_COUNT, CFG_DATA_W'(inits[ph]));
            end
            random_run(118);
            if (ph == 5)
            begin
                settle();
                write_reg(CFG_SPARE_LO, '1);
                write_reg(CFG_SPARE_HI, '0);
                random_run(40);
            end
        end

        settle();
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/derq_pkg.sv
hdl/double_ended_ring_queue.sv
hdl/derq_checker.sv
tb/tb_double_ended_ring_queue.sv
